[rtl/axhms_pkg.sv]
// package for the homing and move supervisor: request and response word types,
// request, fault and mode codes, and register indexes with their reset values
// no dependencies
package axhms_pkg;

   typedef enum logic [2:0] {
      REQ_UPDATE      = 3'd0,
      REQ_START_HOME  = 3'd1,
      REQ_START_MOVE  = 3'd2,
      REQ_STOP        = 3'd3,
      REQ_CLEAR_REF   = 3'd4
   } req_code_type;

   localparam logic [2:0] FAULT_NONE     = 3'd0;
   localparam logic [2:0] FAULT_DRIVER   = 3'd1;
   localparam logic [2:0] FAULT_OBSTACLE = 3'd2;
   localparam logic [2:0] FAULT_HOME_TO  = 3'd3;
   localparam logic [2:0] FAULT_MOVE_TO  = 3'd4;
   localparam logic [2:0] FAULT_POSITION = 3'd5;

   localparam logic [1:0] MODE_CODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_CODE_HOMING = 2'd1;
   localparam logic [1:0] MODE_CODE_MOVING = 2'd2;

   localparam logic [1:0] DIR_POSITIVE = 2'd1;
   localparam logic [1:0] DIR_NEGATIVE = 2'd2;

   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOME_POSITION   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEARCH_DISTANCE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOMING_TIMEOUT  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MOVE_TIMEOUT    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MOVE_TOLERANCE  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOMING_SPEED    = 3'd5;

   localparam logic signed [31:0] HOME_POSITION_RST   = 32'sd0;
   localparam logic [30:0]        SEARCH_DISTANCE_RST = 31'd20000;
   localparam logic [31:0]        HOMING_TIMEOUT_RST  = 32'd30000;
   localparam logic [31:0]        MOVE_TIMEOUT_RST    = 32'd30000;
   localparam logic [15:0]        MOVE_TOLERANCE_RST  = 16'd2;
   localparam logic [19:0]        HOMING_SPEED_RST    = 20'd1000;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [31:0]        now_ms;
      logic signed [31:0] move_target;
      logic [19:0]        move_speed;
      logic signed [31:0] axis_position;
      logic               axis_moving;
      logic [1:0]         axis_direction;
      logic               driver_fault;
      logic               front_obstacle;
      logic               rear_obstacle;
      logic               home_detected;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         fault_code;
      logic               home_completed;
      logic               move_completed;
      logic               accepted;
      logic               axis_stop;
      logic               axis_move;
      logic signed [31:0] axis_move_target;
      logic [19:0]        axis_move_speed;
      logic               axis_reset_position;
      logic [1:0]         mode;
      logic               referenced;
   } rsp_word_type;

endpackage

[rtl/axis_homing_move_supervisor_unit.sv]
// a request word passes through the input register and then the result register to rsp_data
// throughput: one word per cycle, set by the input register and result register pair, unless rsp_ready stalls it
// the supervisor state is read and updated between the two
// reset (synchronous, active high) empties both registers, returns to idle,
// clears the referenced flag and loads the register reset values
module axis_homing_move_supervisor_unit
   import axhms_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_word_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_word_type               rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_HOMING = 3'b010,
      ST_MOVING = 3'b100
   } run_state_type;

   // configuration registers
   logic signed [31:0] home_position_ff;
   logic [30:0]        search_distance_ff;
   logic [31:0]        homing_timeout_ff;
   logic [31:0]        move_timeout_ff;
   logic [15:0]        move_tolerance_ff;
   logic [19:0]        homing_speed_ff;

   // supervisor state
   run_state_type      run_mode_ff, run_mode_in;
   logic               referenced_ff, referenced_in;
   logic [31:0]        start_time_ff, start_time_in;
   logic signed [31:0] home_start_ff, home_start_in;
   logic signed [31:0] target_ff, target_in;

   // pipeline
   logic               in_valid_ff;
   req_word_type       in_word_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   logic               advance;

   logic signed [32:0] home_diff;
   logic [32:0]        home_dist;
   logic signed [32:0] move_diff;
   logic [32:0]        move_dist;
   logic signed [32:0] home_goal_wide;
   logic signed [31:0] home_goal;
   logic [31:0]        elapsed;
   logic               home_reached;
   logic               move_in_tol;
   logic               obstacle_ahead;
   logic [2:0]         fault;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;
   assign csr_ready = 1'b1;

   assign home_diff = {in_word_ff.axis_position[31], in_word_ff.axis_position}
                      - {home_start_ff[31], home_start_ff};
   assign home_dist = home_diff[32] ? 33'(-home_diff) : 33'(home_diff);
   assign move_diff = {in_word_ff.axis_position[31], in_word_ff.axis_position}
                      - {target_ff[31], target_ff};
   assign move_dist = move_diff[32] ? 33'(-move_diff) : 33'(move_diff);

   // only underflow is possible; clamp to the most negative position
   assign home_goal_wide = {in_word_ff.axis_position[31], in_word_ff.axis_position}
                           - {2'b00, search_distance_ff};
   assign home_goal = (home_goal_wide[32] != home_goal_wide[31]) ?
                      {1'b1, 31'd0} : home_goal_wide[31:0];

   assign elapsed      = in_word_ff.now_ms - start_time_ff;
   assign home_reached = in_word_ff.home_detected || (home_dist >= {2'b00, search_distance_ff});
   assign move_in_tol  = move_dist <= {17'd0, move_tolerance_ff};
   assign obstacle_ahead =
      ((in_word_ff.axis_direction == DIR_POSITIVE) && in_word_ff.front_obstacle) ||
      ((in_word_ff.axis_direction == DIR_NEGATIVE) && in_word_ff.rear_obstacle);

   always_comb begin
      rsp_word_in   = '0;
      run_mode_in   = run_mode_ff;
      referenced_in = referenced_ff;
      start_time_in = start_time_ff;
      home_start_in = home_start_ff;
      target_in     = target_ff;
      fault         = FAULT_NONE;

      unique case (in_word_ff.req_type)
         REQ_UPDATE: begin
            if (in_word_ff.driver_fault) begin
               fault = FAULT_DRIVER;
            end else if (run_mode_ff == ST_HOMING) begin
               if (in_word_ff.front_obstacle || in_word_ff.rear_obstacle) begin
                  fault = FAULT_OBSTACLE;
               end else if (home_reached) begin
                  rsp_word_in.axis_stop           = 1'b1;
                  rsp_word_in.axis_reset_position = 1'b1;
                  rsp_word_in.home_completed      = 1'b1;
                  referenced_in = 1'b1;
                  run_mode_in   = ST_IDLE;
               end else if (elapsed > homing_timeout_ff) begin
                  fault = FAULT_HOME_TO;
               end
            end else if (run_mode_ff == ST_MOVING) begin
               if (obstacle_ahead) begin
                  fault = FAULT_OBSTACLE;
               end else if (elapsed > move_timeout_ff) begin
                  fault = FAULT_MOVE_TO;
               end else if (!in_word_ff.axis_moving) begin
                  if (move_in_tol) begin
                     rsp_word_in.move_completed = 1'b1;
                     run_mode_in = ST_IDLE;
                  end else begin
                     fault = FAULT_POSITION;
                  end
               end
            end
            // every fault stops the axis
            if (fault != FAULT_NONE) begin
               rsp_word_in.axis_stop = 1'b1;
               run_mode_in = ST_IDLE;
            end
         end
         REQ_START_HOME: begin
            if (run_mode_ff == ST_IDLE) begin
               start_time_in = in_word_ff.now_ms;
               home_start_in = in_word_ff.axis_position;
               target_in     = home_goal;
               run_mode_in   = ST_HOMING;
               referenced_in = 1'b0;
               rsp_word_in.axis_move        = 1'b1;
               rsp_word_in.axis_move_target = home_goal;
               rsp_word_in.axis_move_speed  = homing_speed_ff;
               rsp_word_in.accepted         = 1'b1;
            end
         end
         REQ_START_MOVE: begin
            if ((run_mode_ff == ST_IDLE) && referenced_ff) begin
               start_time_in = in_word_ff.now_ms;
               target_in     = in_word_ff.move_target;
               run_mode_in   = ST_MOVING;
               rsp_word_in.axis_move        = 1'b1;
               rsp_word_in.axis_move_target = in_word_ff.move_target;
               rsp_word_in.axis_move_speed  = in_word_ff.move_speed;
               rsp_word_in.accepted         = 1'b1;
            end
         end
         REQ_STOP: begin
            rsp_word_in.axis_stop = 1'b1;
            run_mode_in = ST_IDLE;
         end
         REQ_CLEAR_REF: begin
            rsp_word_in.axis_reset_position = 1'b1;
            referenced_in = 1'b0;
            run_mode_in   = ST_IDLE;
         end
         default: begin
            // unused request codes leave everything as it is
         end
      endcase

      rsp_word_in.fault_code = fault;
      rsp_word_in.referenced = referenced_in;
      unique case (run_mode_in)
         ST_HOMING: rsp_word_in.mode = MODE_CODE_HOMING;
         ST_MOVING: rsp_word_in.mode = MODE_CODE_MOVING;
         default:   rsp_word_in.mode = MODE_CODE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         run_mode_ff   <= ST_IDLE;
         referenced_ff <= 1'b0;
         start_time_ff <= '0;
         home_start_ff <= '0;
         target_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            run_mode_ff   <= run_mode_in;
            referenced_ff <= referenced_in;
            start_time_ff <= start_time_in;
            home_start_ff <= home_start_in;
            target_ff     <= target_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_position_ff   <= HOME_POSITION_RST;
         search_distance_ff <= SEARCH_DISTANCE_RST;
         homing_timeout_ff  <= HOMING_TIMEOUT_RST;
         move_timeout_ff    <= MOVE_TIMEOUT_RST;
         move_tolerance_ff  <= MOVE_TOLERANCE_RST;
         homing_speed_ff    <= HOMING_SPEED_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HOME_POSITION:   home_position_ff   <= csr_wdata;
            CSR_SEARCH_DISTANCE: search_distance_ff <= csr_wdata[30:0];
            CSR_HOMING_TIMEOUT:  homing_timeout_ff  <= csr_wdata;
            CSR_MOVE_TIMEOUT:    move_timeout_ff    <= csr_wdata;
            CSR_MOVE_TOLERANCE:  move_tolerance_ff  <= csr_wdata[15:0];
            CSR_HOMING_SPEED:    homing_speed_ff    <= csr_wdata[19:0];
            default: begin
               // writes past the register list are dropped
            end
         endcase
      end
   end

   // home position is held in its register but drives no port;
   // it does not enter the response word
   logic home_position_unused;
   assign home_position_unused = ^home_position_ff;

endmodule

[verif/tb_axis_homing_move_supervisor_unit.sv]
// testbench for axis_homing_move_supervisor_unit: drives request words and register writes,
// mirrors the supervisor state to predict every response word and checks them in order
// depends on axhms_pkg and the unit itself
`timescale 1ns / 1ps

module tb_axis_homing_move_supervisor_unit;
   import axhms_pkg::*;

   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
   localparam logic [2:0] REQ_CODE_MAX = 3'd7;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned PHASE_ITEMS = 450;

   // mirror of the supervisor: register copy, mode state and the queue of awaited responses
   class supervisor_mirror;
      logic signed [31:0] home_pos;
      logic [30:0]        search_dist;
      logic [31:0]        homing_timeout;
      logic [31:0]        move_timeout;
      logic [15:0]        tolerance;
      logic [19:0]        homing_speed;
      logic [1:0]         run_mode;
      logic               referenced;
      logic [31:0]        op_start_ms;
      logic signed [31:0] home_start_pos;
      logic signed [31:0] target_pos;
      rsp_word_type       awaited_rsp[$];
      int unsigned        failures;

      function new();
         home_pos       = HOME_POSITION_RST;
         search_dist    = SEARCH_DISTANCE_RST;
         homing_timeout = HOMING_TIMEOUT_RST;
         move_timeout   = MOVE_TIMEOUT_RST;
         tolerance      = MOVE_TOLERANCE_RST;
         homing_speed   = HOMING_SPEED_RST;
         run_mode       = MODE_CODE_IDLE;
         referenced     = 1'b0;
         op_start_ms    = '0;
         home_start_pos = '0;
         target_pos     = '0;
         failures       = 0;
      endfunction

      function longint span(logic signed [31:0] a, logic signed [31:0] b);
         longint d;
         d = longint'(a) - longint'(b);
         return (d < 0) ? -d : d;
      endfunction

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_HOME_POSITION:   home_pos = data;
            CSR_SEARCH_DISTANCE: search_dist = data[30:0];
            CSR_HOMING_TIMEOUT:  homing_timeout = data;
            CSR_MOVE_TIMEOUT:    move_timeout = data;
            CSR_MOVE_TOLERANCE:  tolerance = data[15:0];
            CSR_HOMING_SPEED:    homing_speed = data[19:0];
            default: ;
         endcase
      endfunction

      function void take_request(req_word_type r);
         rsp_word_type want;
         logic [31:0]  elapsed;
         longint       travel_end;
         want    = '0;
         elapsed = r.now_ms - op_start_ms;
         case (r.req_type)
            REQ_UPDATE: begin
               if (r.driver_fault) begin
                  want.fault_code = FAULT_DRIVER;
               end else if (run_mode == MODE_CODE_HOMING) begin
                  if (r.front_obstacle || r.rear_obstacle) begin
                     want.fault_code = FAULT_OBSTACLE;
                  end else if (r.home_detected ||
                               span(r.axis_position, home_start_pos) >= longint'(search_dist)) begin
                     want.axis_stop           = 1'b1;
                     want.axis_reset_position = 1'b1;
                     want.home_completed      = 1'b1;
                     referenced               = 1'b1;
                     run_mode                 = MODE_CODE_IDLE;
                  end else if (elapsed > homing_timeout) begin
                     want.fault_code = FAULT_HOME_TO;
                  end
               end else if (run_mode == MODE_CODE_MOVING) begin
                  if ((r.axis_direction == DIR_POSITIVE && r.front_obstacle) ||
                      (r.axis_direction == DIR_NEGATIVE && r.rear_obstacle)) begin
                     want.fault_code = FAULT_OBSTACLE;
                  end else if (elapsed > move_timeout) begin
                     want.fault_code = FAULT_MOVE_TO;
                  end else if (!r.axis_moving) begin
                     if (span(r.axis_position, target_pos) <= longint'(tolerance)) begin
                        want.move_completed = 1'b1;
                        run_mode            = MODE_CODE_IDLE;
                     end else begin
                        want.fault_code = FAULT_POSITION;
                     end
                  end
               end
               if (want.fault_code != FAULT_NONE) begin
                  want.axis_stop = 1'b1;
                  run_mode       = MODE_CODE_IDLE;
               end
            end
            REQ_START_HOME: begin
               if (run_mode == MODE_CODE_IDLE) begin
                  // search target saturates at the bottom of the position range
                  travel_end = longint'(r.axis_position) - longint'(search_dist);
                  if (travel_end < longint'(POS_MIN)) travel_end = longint'(POS_MIN);
                  op_start_ms           = r.now_ms;
                  home_start_pos        = r.axis_position;
                  target_pos            = 32'(travel_end);
                  run_mode              = MODE_CODE_HOMING;
                  referenced            = 1'b0;
                  want.axis_move        = 1'b1;
                  want.axis_move_target = 32'(travel_end);
                  want.axis_move_speed  = homing_speed;
                  want.accepted         = 1'b1;
               end
            end
            REQ_START_MOVE: begin
               if (run_mode == MODE_CODE_IDLE && referenced) begin
                  op_start_ms           = r.now_ms;
                  target_pos            = r.move_target;
                  run_mode              = MODE_CODE_MOVING;
                  want.axis_move        = 1'b1;
                  want.axis_move_target = r.move_target;
                  want.axis_move_speed  = r.move_speed;
                  want.accepted         = 1'b1;
               end
            end
            REQ_STOP: begin
               want.axis_stop = 1'b1;
               run_mode       = MODE_CODE_IDLE;
            end
            REQ_CLEAR_REF: begin
               want.axis_reset_position = 1'b1;
               referenced               = 1'b0;
               run_mode                 = MODE_CODE_IDLE;
            end
            default: ;
         endcase
         want.mode       = run_mode;
         want.referenced = referenced;
         awaited_rsp.push_back(want);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (awaited_rsp.size() == 0) begin
            failures++;
            if (failures <= 10) $display("response word with nothing awaited: %p", got);
            return;
         end
         want = awaited_rsp.pop_front();
         if (got.fault_code !== want.fault_code ||
             got.home_completed !== want.home_completed ||
             got.move_completed !== want.move_completed ||
             got.accepted !== want.accepted ||
             got.axis_stop !== want.axis_stop ||
             got.axis_move !== want.axis_move ||
             got.axis_move_target !== want.axis_move_target ||
             got.axis_move_speed !== want.axis_move_speed ||
             got.axis_reset_position !== want.axis_reset_position ||
             got.mode !== want.mode ||
             got.referenced !== want.referenced) begin
            failures++;
            if (failures <= 10) $display("response mismatch\n  expected %p\n  actual   %p", want, got);
         end
      endfunction

      function int unsigned pending();
         return awaited_rsp.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_word_type               req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_word_type               rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]                csr_wdata = '0;

   supervisor_mirror   tracker = new();
   bit                 idling_on = 1'b1;
   int unsigned        items_sent = 0;
   int unsigned        cycle_count = 0;
   logic [31:0]        sim_ms = '0;
   logic signed [31:0] carriage_pos = '0;

   axis_homing_move_supervisor_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_response(rsp_data);
   end

   // result side back-pressure in bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   function automatic req_word_type req_word(req_code_type code, logic [31:0] stamp,
                                             logic signed [31:0] pos);
      req_word_type w;
      w               = '0;
      w.req_type      = code;
      w.now_ms        = stamp;
      w.axis_position = pos;
      return w;
   endfunction

   function automatic req_word_type with_sensor_noise(req_word_type w);
      w.driver_fault   = ($urandom_range(0, 49) == 0);
      w.front_obstacle = ($urandom_range(0, 24) == 0);
      w.rear_obstacle  = ($urandom_range(0, 24) == 0);
      w.move_target    = $urandom;
      w.move_speed     = 20'($urandom);
      return w;
   endfunction

   function automatic logic signed [31:0] clamp_pos(longint v);
      if (v > longint'(POS_MAX)) return POS_MAX;
      if (v < longint'(POS_MIN)) return POS_MIN;
      return 32'(v);
   endfunction

   // mostly short steps, now and then a random jump across the whole time range
   function automatic logic [31:0] ms_step();
      if ($urandom_range(0, 19) == 0) return $urandom;
      return $urandom_range(0, 600);
   endfunction

   task automatic send_req(req_word_type w);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      tracker.take_request(w);
      if (w.req_type <= REQ_CLEAR_REF) items_sent++;
   endtask

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(idx, data);
   endtask

   // registers change only once every response word is home
   task automatic write_settings(logic signed [31:0] hp, logic [30:0] sd, logic [31:0] ht,
                                 logic [31:0] mt, logic [15:0] tol, logic [19:0] spd);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write(CSR_HOME_POSITION, hp);
      csr_write(CSR_SEARCH_DISTANCE, {1'($urandom), sd});
      csr_write(CSR_HOMING_TIMEOUT, ht);
      csr_write(CSR_MOVE_TIMEOUT, mt);
      csr_write(CSR_MOVE_TOLERANCE, {16'($urandom), tol});
      csr_write(CSR_HOMING_SPEED, {12'($urandom), spd});
      csr_write(CSR_SPARE_LO, $urandom);
      csr_write(CSR_SPARE_HI, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic stray_request();
      req_word_type w;
      w             = req_word(req_code_type'($urandom_range(1, 4)), sim_ms, carriage_pos);
      w.move_target = $urandom;
      w.move_speed  = 20'($urandom);
      send_req(w);
   endtask

   task automatic noise_word();
      req_word_type w;
      w          = req_word_type'(126'({$urandom, $urandom, $urandom, $urandom}));
      w.req_type = 3'($urandom_range(0, REQ_CODE_MAX));
      if ($urandom_range(0, 1) == 0) w.now_ms = sim_ms;
      send_req(w);
   endtask

   task automatic homing_run();
      req_word_type w;
      int unsigned  steps;
      int unsigned  stride;
      if (tracker.run_mode != MODE_CODE_IDLE) send_req(req_word(REQ_STOP, sim_ms, carriage_pos));
      if ($urandom_range(0, 3) == 0) carriage_pos = $urandom;
      else carriage_pos = int'($urandom_range(0, 40000)) - 20000;
      sim_ms += ms_step();
      send_req(req_word(REQ_START_HOME, sim_ms, carriage_pos));
      stride = (tracker.search_dist < 31'd8000) ? int'(tracker.search_dist) / 2 + 2 : 6000;
      steps  = $urandom_range(1, 10);
      for (int i = 0; i < steps; i++) begin
         if (tracker.run_mode != MODE_CODE_HOMING) break;
         sim_ms += ms_step();
         if ($urandom_range(0, 11) == 0) begin
            stray_request();
         end else begin
            carriage_pos = clamp_pos(longint'(carriage_pos) - longint'($urandom_range(0, stride)));
            w                = with_sensor_noise(req_word(REQ_UPDATE, sim_ms, carriage_pos));
            w.axis_moving    = 1'b1;
            w.axis_direction = DIR_NEGATIVE;
            w.home_detected  = ($urandom_range(0, 7) == 0);
            send_req(w);
         end
      end
   endtask

   task automatic move_run();
      req_word_type       w;
      logic signed [31:0] goal;
      int unsigned        steps;
      int unsigned        tol;
      longint             offset;
      if (!tracker.referenced) homing_run();
      if (tracker.run_mode != MODE_CODE_IDLE) send_req(req_word(REQ_STOP, sim_ms, carriage_pos));
      if ($urandom_range(0, 7) == 0) goal = $urandom;
      else goal = clamp_pos(longint'(carriage_pos) + longint'(int'($urandom_range(0, 100000)) - 50000));
      sim_ms += ms_step();
      w             = req_word(REQ_START_MOVE, sim_ms, carriage_pos);
      w.move_target = goal;
      w.move_speed  = 20'($urandom);
      send_req(w);
      steps = $urandom_range(0, 6);
      for (int i = 0; i < steps; i++) begin
         if (tracker.run_mode != MODE_CODE_MOVING) break;
         sim_ms += ms_step();
         if ($urandom_range(0, 11) == 0) begin
            stray_request();
         end else begin
            carriage_pos = clamp_pos(longint'(carriage_pos) +
                                     (longint'(goal) - longint'(carriage_pos)) / 2);
            w             = with_sensor_noise(req_word(REQ_UPDATE, sim_ms, carriage_pos));
            w.axis_moving = 1'b1;
            if ($urandom_range(0, 9) == 0) w.axis_direction = 2'($urandom_range(0, 3));
            else w.axis_direction = (goal > carriage_pos) ? DIR_POSITIVE : DIR_NEGATIVE;
            send_req(w);
         end
      end
      if (tracker.run_mode == MODE_CODE_MOVING) begin
         // settle around the target within the tolerance plus two on either side, now and then far off
         tol    = tracker.tolerance;
         offset = longint'($urandom_range(0, 2 * tol + 4)) - longint'(tol) - 2;
         if ($urandom_range(0, 5) == 0) offset = longint'(int'($urandom));
         carriage_pos = clamp_pos(longint'(goal) + offset);
         sim_ms += ms_step();
         w                = with_sensor_noise(req_word(REQ_UPDATE, sim_ms, carriage_pos));
         w.axis_direction = 2'($urandom_range(0, 3));
         send_req(w);
      end
   endtask

   task automatic random_items(int unsigned n);
      int unsigned goal_count;
      goal_count = items_sent + n;
      while (items_sent < goal_count) begin
         case ($urandom_range(0, 9))
            0, 1:          homing_run();
            2, 3, 4, 5, 6: move_run();
            7:             stray_request();
            default: begin
               repeat ($urandom_range(1, 4)) noise_word();
            end
         endcase
      end
   endtask

   initial begin
      req_word_type w;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset register values
      send_req(req_word(REQ_UPDATE, 32'd0, 32'sd0));
      w             = req_word(REQ_START_MOVE, 32'd1, 32'sd0);
      w.move_target = 32'sd100;
      w.move_speed  = 20'd5;
      send_req(w);                                            // refused, not referenced
      send_req(req_word(REQ_CLEAR_REF, 32'd2, 32'sd0));
      send_req(req_word(REQ_START_HOME, 32'hffff_fff0, POS_MIN + 32'sd5));  // saturated target
      send_req(req_word(REQ_START_HOME, 32'hffff_fff1, 32'sd0));             // refused, busy
      w                = req_word(REQ_UPDATE, 32'd5, POS_MIN + 32'sd5);      // time wraps
      w.axis_moving    = 1'b1;
      w.axis_direction = DIR_NEGATIVE;
      w.home_detected  = 1'b1;
      send_req(w);
      w             = req_word(REQ_START_MOVE, 32'd100, 32'sd0);
      w.move_target = POS_MAX;
      w.move_speed  = '1;
      send_req(w);
      w                = req_word(REQ_UPDATE, 32'd200, 32'sd0);
      w.axis_moving    = 1'b1;
      w.axis_direction = '1;                                  // undefined direction ignores sensors
      w.front_obstacle = 1'b1;
      w.rear_obstacle  = 1'b1;
      send_req(w);
      w                = req_word(REQ_UPDATE, 32'd300, POS_MAX - 32'sd2);
      w.axis_direction = DIR_POSITIVE;
      send_req(w);
      w             = req_word(REQ_START_MOVE, 32'd400, POS_MAX);
      w.move_target = POS_MIN;
      send_req(w);
      w                = req_word(REQ_UPDATE, 32'd500, 32'sd0);
      w.axis_moving    = 1'b1;
      w.axis_direction = DIR_NEGATIVE;
      w.rear_obstacle  = 1'b1;
      send_req(w);
      w             = req_word(REQ_START_MOVE, 32'd600, 32'sd0);
      w.move_target = 32'sd1000;
      w.move_speed  = 20'd300;
      send_req(w);
      w             = req_word(REQ_UPDATE, 32'd30600, 32'sd10);  // right on the move timeout
      w.axis_moving = 1'b1;
      send_req(w);
      w             = req_word(REQ_UPDATE, 32'd30601, 32'sd20);
      w.axis_moving = 1'b1;
      send_req(w);
      w             = req_word(REQ_START_MOVE, 32'd0, 32'sd0);
      w.move_target = 32'sd1000;
      send_req(w);
      send_req(req_word(REQ_UPDATE, 32'd1, 32'sd1003));         // just outside tolerance
      send_req(w);
      send_req(req_word(REQ_STOP, 32'd2, 32'sd500));
      send_req(req_word(REQ_START_HOME, 32'd0, POS_MAX));
      w                = req_word(REQ_UPDATE, 32'd1, POS_MAX);
      w.front_obstacle = 1'b1;
      send_req(w);
      send_req(req_word(REQ_START_HOME, 32'd10, 32'sd0));
      send_req(req_word(REQ_UPDATE, 32'd30010, 32'sd0));        // right on the homing timeout
      send_req(req_word(REQ_UPDATE, 32'd30011, 32'sd0));
      send_req(req_word(REQ_START_HOME, 32'd0, 32'sd0));
      w              = req_word(REQ_UPDATE, 32'd1, 32'sd0);
      w.driver_fault = 1'b1;
      send_req(w);
      send_req(req_word(REQ_START_HOME, 32'd0, 32'sd0));
      send_req(req_word(REQ_UPDATE, 32'd1, -32'sd20000));       // search distance reached
      w             = req_word(REQ_START_MOVE, 32'd2, 32'sd0);
      w.move_target = 32'sd7;
      w.move_speed  = 20'd9;
      send_req(w);
      send_req(req_word(REQ_CLEAR_REF, 32'd3, 32'sd0));
      send_req(req_word_type'('1));                             // undefined request code

      random_items(PHASE_ITEMS);
      write_settings(POS_MIN, '0, '0, '0, '0, '0);
      random_items(PHASE_ITEMS);
      write_settings($urandom, 31'($urandom_range(50, 5000)), $urandom_range(100, 4000),
                     $urandom_range(100, 4000), 16'($urandom_range(0, 20)), 20'($urandom));
      random_items(PHASE_ITEMS);
      idling_on = 1'b0;
      write_settings(POS_MAX, '1, '1, '1, '1, '1);
      random_items(PHASE_ITEMS);

      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[axis_homing_move_supervisor_unit.f]
rtl/axhms_pkg.sv
rtl/axis_homing_move_supervisor_unit.sv
verif/tb_axis_homing_move_supervisor_unit.sv
